/* hw/rtl/irc_message_tokenizer_assert.svh */
// Assertion macros shared by the tokenizer RTL
`ifndef IRC_MESSAGE_TOKENIZER_ASSERT_SVH
`define IRC_MESSAGE_TOKENIZER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IRC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");

// next-cycle implication, checked out of reset
`define IRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");

`endif

/* hw/rtl/irc_tok_pkg.sv */
// Types and constants for the IRC message tokenizer
`timescale 1ns / 1ps

package irc_tok_pkg;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [2:0] ROLE_DELIM  = 3'd0;
	localparam logic [2:0] ROLE_PREFIX = 3'd1;
	localparam logic [2:0] ROLE_CMD    = 3'd2;
	localparam logic [2:0] ROLE_PARAM  = 3'd3;
	localparam logic [2:0] ROLE_TRAIL  = 3'd4;
	localparam logic [2:0] ROLE_EOL    = 3'd5;

	typedef enum logic [2:0] {
		MODE_START     = 3'd0,
		MODE_PREFIX    = 3'd1,
		MODE_PRE_CMD   = 3'd2,
		MODE_CMD       = 3'd3,
		MODE_PRE_PARAM = 3'd4,
		MODE_PARAM     = 3'd5,
		MODE_TRAIL     = 3'd6
	} parse_mode_t;

	typedef struct packed {
		logic [7:0] echo_byte;
		logic [2:0] role;
		logic       field_start;
		logic [3:0] param_index;
		logic       end_of_message;
		logic       message_ok;
		logic [3:0] param_total;
		logic       had_prefix;
	} tok_result_t;

endpackage

/* hw/rtl/irc_tok_core.sv */
// Per-byte tokenizer state machine and result tagging
`timescale 1ns / 1ps
`include "irc_message_tokenizer_assert.svh"

module irc_tok_core #(
	parameter logic [3:0] PARAM_CAP = 4'd15
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic [7:0]               data_byte,
	input  logic                     last,
	output irc_tok_pkg::tok_result_t res
);

	irc_tok_pkg::parse_mode_t mode_q, mode_d, mode_nx;
	logic [3:0] params_q, params_d, params_nx;
	logic       prefix_q, prefix_d, prefix_nx;

	function automatic logic [3:0] sat_inc(input logic [3:0] v);
		sat_inc = (v < PARAM_CAP) ? v + 4'd1 : PARAM_CAP;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= irc_tok_pkg::MODE_START;
			params_q <= 4'd0;
			prefix_q <= 1'b0;
		end else if (adv) begin
			mode_q   <= mode_nx;
			params_q <= params_nx;
			prefix_q <= prefix_nx;
		end
	end

	always_comb begin
		mode_d   = mode_q;
		params_d = params_q;
		prefix_d = prefix_q;
		res      = '0;
		res.echo_byte      = data_byte;
		res.role           = irc_tok_pkg::ROLE_DELIM;
		res.end_of_message = last;
		if (data_byte == irc_tok_pkg::CH_CR || data_byte == irc_tok_pkg::CH_LF) begin
			res.role = irc_tok_pkg::ROLE_EOL;
		end else begin
			case (mode_q)
				irc_tok_pkg::MODE_PREFIX: begin
					if (data_byte == irc_tok_pkg::CH_SPACE) begin
						mode_d = irc_tok_pkg::MODE_PRE_CMD;
					end else begin
						res.role = irc_tok_pkg::ROLE_PREFIX;
					end
				end
				irc_tok_pkg::MODE_PRE_CMD: begin
					if (data_byte != irc_tok_pkg::CH_SPACE) begin
						mode_d          = irc_tok_pkg::MODE_CMD;
						res.role        = irc_tok_pkg::ROLE_CMD;
						res.field_start = 1'b1;
					end
				end
				irc_tok_pkg::MODE_CMD: begin
					if (data_byte == irc_tok_pkg::CH_SPACE) begin
						mode_d = irc_tok_pkg::MODE_PRE_PARAM;
					end else begin
						res.role = irc_tok_pkg::ROLE_CMD;
					end
				end
				irc_tok_pkg::MODE_PRE_PARAM: begin
					if (data_byte == irc_tok_pkg::CH_COLON) begin
						mode_d          = irc_tok_pkg::MODE_TRAIL;
						res.role        = irc_tok_pkg::ROLE_TRAIL;
						res.field_start = 1'b1;
						res.param_index = params_q;
					end else if (data_byte != irc_tok_pkg::CH_SPACE) begin
						mode_d          = irc_tok_pkg::MODE_PARAM;
						res.role        = irc_tok_pkg::ROLE_PARAM;
						res.field_start = 1'b1;
						res.param_index = params_q;
					end
				end
				irc_tok_pkg::MODE_PARAM: begin
					if (data_byte == irc_tok_pkg::CH_SPACE) begin
						params_d = sat_inc(params_q);
						mode_d   = irc_tok_pkg::MODE_PRE_PARAM;
					end else begin
						res.role        = irc_tok_pkg::ROLE_PARAM;
						res.param_index = params_q;
					end
				end
				irc_tok_pkg::MODE_TRAIL: begin
					res.role        = irc_tok_pkg::ROLE_TRAIL;
					res.param_index = params_q;
				end
				default: begin
					if (data_byte == irc_tok_pkg::CH_COLON) begin
						mode_d          = irc_tok_pkg::MODE_PREFIX;
						prefix_d        = 1'b1;
						res.role        = irc_tok_pkg::ROLE_PREFIX;
						res.field_start = 1'b1;
					end else if (data_byte == irc_tok_pkg::CH_SPACE) begin
						mode_d = irc_tok_pkg::MODE_PRE_CMD;
					end else begin
						mode_d          = irc_tok_pkg::MODE_CMD;
						res.role        = irc_tok_pkg::ROLE_CMD;
						res.field_start = 1'b1;
					end
				end
			endcase
		end

		mode_nx   = mode_d;
		params_nx = params_d;
		prefix_nx = prefix_d;
		if (last) begin
			res.message_ok = (mode_d == irc_tok_pkg::MODE_CMD)
				|| (mode_d == irc_tok_pkg::MODE_PRE_PARAM)
				|| (mode_d == irc_tok_pkg::MODE_PARAM)
				|| (mode_d == irc_tok_pkg::MODE_TRAIL);
			res.param_total = (mode_d == irc_tok_pkg::MODE_PARAM) ? sat_inc(params_d) : params_d;
			res.had_prefix  = prefix_d;
			mode_nx   = irc_tok_pkg::MODE_START;
			params_nx = 4'd0;
			prefix_nx = 1'b0;
		end
	end

	`IRC_ASSERT_NEXT(a_line_end_clears, clk, arst_n, adv && last,
		mode_q == irc_tok_pkg::MODE_START && params_q == 4'd0 && !prefix_q)
	`IRC_ASSERT_IMPLY(a_params_capped, clk, arst_n, 1'b1, params_q <= PARAM_CAP)
	`IRC_ASSERT_IMPLY(a_summary_on_end, clk, arst_n,
		res.message_ok || res.had_prefix || res.param_total != 4'd0, res.end_of_message)
	`IRC_ASSERT_NEXT(a_state_holds, clk, arst_n, !adv,
		$stable(mode_q) && $stable(params_q) && $stable(prefix_q))

endmodule

/* hw/rtl/irc_message_tokenizer.sv */
// Top level of the IRC message tokenizer: input register, tagging core, result register
`timescale 1ns / 1ps

// Tags one IRC line, one byte per transaction, with its role (prefix, command,
// parameter, trailing, delimiter, line end) and reports message_ok, param_total
// and had_prefix on the byte marked last. Sustains one byte per clock while no
// result waits on tag_stall. The input register takes an accepted byte and the
// result register then takes its tag, with the tagging state machine between
// them. The input register also absorbs one byte while a result waits on
// tag_stall. Parameter counts saturate at the smaller of MAX_PARAMS and 15.
module irc_message_tokenizer #(
	parameter int unsigned MAX_PARAMS = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       tag_valid,
	input  logic       tag_stall,
	output logic [7:0] echo_byte,
	output logic [2:0] role,
	output logic       field_start,
	output logic [3:0] param_index,
	output logic       end_of_message,
	output logic       message_ok,
	output logic [3:0] param_total,
	output logic       had_prefix
);

	localparam logic [3:0] PARAM_CAP = (MAX_PARAMS < 15) ? 4'(MAX_PARAMS) : 4'd15;

	logic                     valid_s1;
	logic [7:0]               byte_s1;
	logic                     last_s1;
	logic                     tag_valid_q;
	irc_tok_pkg::tok_result_t res;
	irc_tok_pkg::tok_result_t res_q;
	logic                     out_free;
	logic                     adv;

	assign out_free   = !tag_valid_q || !tag_stall;
	assign adv        = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	irc_tok_core #(
		.PARAM_CAP(PARAM_CAP)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.data_byte(byte_s1),
		.last     (last_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_valid_q <= 1'b0;
		end else if (out_free) begin
			tag_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign tag_valid      = tag_valid_q;
	assign echo_byte      = res_q.echo_byte;
	assign role           = res_q.role;
	assign field_start    = res_q.field_start;
	assign param_index    = res_q.param_index;
	assign end_of_message = res_q.end_of_message;
	assign message_ok     = res_q.message_ok;
	assign param_total    = res_q.param_total;
	assign had_prefix     = res_q.had_prefix;

endmodule

/* test/irc_message_tokenizer_tb.sv */
// Self-checking testbench for the IRC message tokenizer: directed and random lines
`timescale 1ns / 1ps

module irc_message_tokenizer_tb;

	localparam int unsigned MAX_PARAMS = 15;
	localparam int unsigned PARAM_CAP = (MAX_PARAMS < 15) ? MAX_PARAMS : 15;
	localparam int unsigned RANDOM_ITEMS = 1700;

	class tok_scoreboard;
		irc_tok_pkg::parse_mode_t mode;
		logic [3:0] params_seen;
		logic prefix_seen;
		irc_tok_pkg::tok_result_t expected_q[$];
		int mismatches;

		function new();
			mode = irc_tok_pkg::MODE_START;
			params_seen = '0;
			prefix_seen = 1'b0;
			mismatches = 0;
		endfunction

		function logic [3:0] bump(logic [3:0] v);
			return (v < PARAM_CAP) ? v + 4'd1 : PARAM_CAP[3:0];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_byte(logic [7:0] b, logic is_last);
			irc_tok_pkg::tok_result_t e;
			e = '0;
			e.echo_byte = b;
			e.end_of_message = is_last;
			e.role = irc_tok_pkg::ROLE_DELIM;
			if (b == irc_tok_pkg::CH_CR || b == irc_tok_pkg::CH_LF) begin
				e.role = irc_tok_pkg::ROLE_EOL;
			end else begin
				case (mode)
					irc_tok_pkg::MODE_PREFIX: begin
						if (b == irc_tok_pkg::CH_SPACE) mode = irc_tok_pkg::MODE_PRE_CMD;
						else e.role = irc_tok_pkg::ROLE_PREFIX;
					end
					irc_tok_pkg::MODE_PRE_CMD: begin
						if (b != irc_tok_pkg::CH_SPACE) begin
							mode = irc_tok_pkg::MODE_CMD;
							e.role = irc_tok_pkg::ROLE_CMD;
							e.field_start = 1'b1;
						end
					end
					irc_tok_pkg::MODE_CMD: begin
						if (b == irc_tok_pkg::CH_SPACE) mode = irc_tok_pkg::MODE_PRE_PARAM;
						else e.role = irc_tok_pkg::ROLE_CMD;
					end
					irc_tok_pkg::MODE_PRE_PARAM: begin
						if (b == irc_tok_pkg::CH_COLON) begin
							mode = irc_tok_pkg::MODE_TRAIL;
							e.role = irc_tok_pkg::ROLE_TRAIL;
							e.field_start = 1'b1;
							e.param_index = params_seen;
						end else if (b != irc_tok_pkg::CH_SPACE) begin
							mode = irc_tok_pkg::MODE_PARAM;
							e.role = irc_tok_pkg::ROLE_PARAM;
							e.field_start = 1'b1;
							e.param_index = params_seen;
						end
					end
					irc_tok_pkg::MODE_PARAM: begin
						if (b == irc_tok_pkg::CH_SPACE) begin
							params_seen = bump(params_seen);
							mode = irc_tok_pkg::MODE_PRE_PARAM;
						end else begin
							e.role = irc_tok_pkg::ROLE_PARAM;
							e.param_index = params_seen;
						end
					end
					irc_tok_pkg::MODE_TRAIL: begin
						e.role = irc_tok_pkg::ROLE_TRAIL;
						e.param_index = params_seen;
					end
					default: begin
						if (b == irc_tok_pkg::CH_COLON) begin
							mode = irc_tok_pkg::MODE_PREFIX;
							prefix_seen = 1'b1;
							e.role = irc_tok_pkg::ROLE_PREFIX;
							e.field_start = 1'b1;
						end else if (b == irc_tok_pkg::CH_SPACE) begin
							mode = irc_tok_pkg::MODE_PRE_CMD;
						end else begin
							mode = irc_tok_pkg::MODE_CMD;
							e.role = irc_tok_pkg::ROLE_CMD;
							e.field_start = 1'b1;
						end
					end
				endcase
			end
			if (is_last) begin
				e.message_ok = (mode == irc_tok_pkg::MODE_CMD ||
					mode == irc_tok_pkg::MODE_PRE_PARAM ||
					mode == irc_tok_pkg::MODE_PARAM || mode == irc_tok_pkg::MODE_TRAIL);
				e.param_total = (mode == irc_tok_pkg::MODE_PARAM) ?
					bump(params_seen) : params_seen;
				e.had_prefix = prefix_seen;
				mode = irc_tok_pkg::MODE_START;
				params_seen = '0;
				prefix_seen = 1'b0;
			end
			expected_q.insert(expected_q.size(), e);
		endfunction

		function void check_result(irc_tok_pkg::tok_result_t got);
			irc_tok_pkg::tok_result_t e;
			logic bad;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected tag transaction: byte=%h role=%0d", got.echo_byte,
						got.role);
				return;
			end
			e = expected_q.pop_front();
			bad = (got.echo_byte !== e.echo_byte) || (got.role !== e.role) ||
				(got.field_start !== e.field_start) || (got.param_index !== e.param_index) ||
				(got.end_of_message !== e.end_of_message) ||
				(got.message_ok !== e.message_ok) || (got.param_total !== e.param_total) ||
				(got.had_prefix !== e.had_prefix);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch exp: byte=%h role=%0d start=%b idx=%0d eom=%b",
						e.echo_byte, e.role, e.field_start, e.param_index, e.end_of_message,
						" ok=%b total=%0d pfx=%b", e.message_ok, e.param_total, e.had_prefix);
					$display("         got: byte=%h role=%0d start=%b idx=%0d eom=%b",
						got.echo_byte, got.role, got.field_start, got.param_index,
						got.end_of_message, " ok=%b total=%0d pfx=%b", got.message_ok,
						got.param_total, got.had_prefix);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic byte_valid;
	logic byte_stall;
	logic [7:0] data_byte;
	logic last;
	logic tag_valid;
	logic tag_stall;
	logic [7:0] echo_byte;
	logic [2:0] role;
	logic field_start;
	logic [3:0] param_index;
	logic end_of_message;
	logic message_ok;
	logic [3:0] param_total;
	logic had_prefix;

	tok_scoreboard sb;
	logic [7:0] line_q[$];
	int items_sent;
	logic tx_burst;
	logic rx_burst;

	irc_message_tokenizer #(
		.MAX_PARAMS(MAX_PARAMS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.data_byte(data_byte),
		.last(last),
		.tag_valid(tag_valid),
		.tag_stall(tag_stall),
		.echo_byte(echo_byte),
		.role(role),
		.field_start(field_start),
		.param_index(param_index),
		.end_of_message(end_of_message),
		.message_ok(message_ok),
		.param_total(param_total),
		.had_prefix(had_prefix)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("irc_message_tokenizer regression: fail");
		$finish;
	end

	task automatic send_byte(logic [7:0] b, logic is_last);
		int gap;
		gap = tx_burst ? 0 : int'($urandom_range(0, 11));
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		last <= is_last;
		do @(posedge clk); while (byte_stall);
		sb.note_byte(b, is_last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_q.size(); i++)
			send_byte(line_q[i], i == line_q.size() - 1);
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic append_byte(logic [7:0] b);
		line_q.insert(line_q.size(), b);
	endtask

	task automatic add_word();
		int n;
		logic [7:0] b;
		n = $urandom_range(1, 4);
		repeat (n) begin
			if ($urandom_range(0, 11) == 0) begin
				b = $urandom_range(0, 1) ? irc_tok_pkg::CH_CR : irc_tok_pkg::CH_LF;
			end else begin
				do b = 8'($urandom_range(0, 255));
				while (b == irc_tok_pkg::CH_SPACE || b == irc_tok_pkg::CH_CR ||
					b == irc_tok_pkg::CH_LF);
			end
			append_byte(b);
		end
	endtask

	task automatic add_spaces();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
		repeat (n) append_byte(irc_tok_pkg::CH_SPACE);
	endtask

	task automatic add_noise_byte();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 5) append_byte(irc_tok_pkg::CH_COLON);
		else if (pick < 10) append_byte(irc_tok_pkg::CH_SPACE);
		else if (pick < 12)
			append_byte($urandom_range(0, 1) ? irc_tok_pkg::CH_CR : irc_tok_pkg::CH_LF);
		else append_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic build_random_line();
		int kind;
		int nparams;
		int n;
		line_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			if ($urandom_range(0, 2) == 0) begin
				append_byte(irc_tok_pkg::CH_COLON);
				add_word();
				add_spaces();
			end else if ($urandom_range(0, 5) == 0) begin
				add_spaces();
			end
			add_word();
			nparams = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 3);
			repeat (nparams) begin
				add_spaces();
				add_word();
			end
			if ($urandom_range(0, 1)) begin
				add_spaces();
				append_byte(irc_tok_pkg::CH_COLON);
				n = $urandom_range(0, 6);
				repeat (n) append_byte(8'($urandom_range(0, 255)));
			end else if ($urandom_range(0, 4) == 0) begin
				add_spaces();
			end
			if ($urandom_range(0, 2) == 0) begin
				append_byte(irc_tok_pkg::CH_CR);
				append_byte(irc_tok_pkg::CH_LF);
			end
		end else if (kind < 85) begin
			case ($urandom_range(0, 3))
				0: begin
					n = $urandom_range(1, 3);
					repeat (n)
						append_byte($urandom_range(0, 1) ? irc_tok_pkg::CH_CR : irc_tok_pkg::CH_LF);
				end
				1: begin
					append_byte(irc_tok_pkg::CH_COLON);
					add_word();
				end
				2: begin
					append_byte(irc_tok_pkg::CH_COLON);
					add_word();
					add_spaces();
				end
				default: add_spaces();
			endcase
		end else begin
			n = $urandom_range(1, 10);
			repeat (n) add_noise_byte();
		end
	endtask

	initial begin
		tag_stall = 1'b0;
		rx_burst = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			irc_tok_pkg::tok_result_t got;
			int gap;
			gap = rx_burst ? 0 : int'($urandom_range(0, 11));
			if (gap > 0) begin
				tag_stall <= 1'b1;
				repeat (gap) @(negedge clk);
				tag_stall <= 1'b0;
			end
			do @(posedge clk); while (!tag_valid);
			got.echo_byte = echo_byte;
			got.role = role;
			got.field_start = field_start;
			got.param_index = param_index;
			got.end_of_message = end_of_message;
			got.message_ok = message_ok;
			got.param_total = param_total;
			got.had_prefix = had_prefix;
			sb.check_result(got);
			if ($urandom_range(0, 59) == 0) rx_burst = ~rx_burst;
			@(negedge clk);
		end
	end

	initial begin
		sb = new();
		items_sent = 0;
		tx_burst = 1'b0;
		byte_valid = 1'b0;
		data_byte = 8'h00;
		last = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// prefix, extreme bytes, param, trailing with colon and space, CR as last
		line_q = '{irc_tok_pkg::CH_COLON, 8'hFF, irc_tok_pkg::CH_SPACE, 8'h00,
			irc_tok_pkg::CH_SPACE, 8'h70, irc_tok_pkg::CH_SPACE, irc_tok_pkg::CH_COLON,
			irc_tok_pkg::CH_COLON, irc_tok_pkg::CH_SPACE, irc_tok_pkg::CH_CR};
		send_line();
		line_q = '{irc_tok_pkg::CH_LF};
		send_line();
		line_q = '{irc_tok_pkg::CH_COLON, 8'h78};
		send_line();
		line_q = '{irc_tok_pkg::CH_SPACE, irc_tok_pkg::CH_SPACE};
		send_line();
		line_q = '{8'h61, irc_tok_pkg::CH_COLON, irc_tok_pkg::CH_SPACE, 8'h62,
			irc_tok_pkg::CH_COLON};
		send_line();
		wait_drained();

		while (items_sent < RANDOM_ITEMS + 21) begin
			build_random_line();
			send_line();
			if ($urandom_range(0, 39) == 0) wait_drained();
			if ($urandom_range(0, 11) == 0) tx_burst = ~tx_burst;
		end
		byte_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("irc_message_tokenizer regression: pass");
		end else begin
			$display("irc_message_tokenizer regression: fail");
		end
		$finish;
	end

endmodule
